@@ rtl/core/y2r_pkg.sv @@
// y2r_pkg: shared widths, limits, conversion constants and helpers for the
// yuv420sp to rgb converter. No dependencies.
`default_nettype none

package y2r_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field widths
    localparam int LUMA_W   = 8;
    localparam int CHROMA_W = 8;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 24;
    localparam int DIM_W    = 13;
    localparam int CH_W     = 18;
    localparam int ACC_W    = 22;

    // apb
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_REVERSE_ORDER = 2'd2,
        CFG_OUTPUT_FORMAT = 2'd3
    } t_cfg_reg;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    localparam logic FMT_ARGB8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    // bt.601 fixed point coefficients
    localparam logic signed [12:0] C_Y    = 13'sd1192;
    localparam logic signed [12:0] C_RV   = 13'sd1634;
    localparam logic signed [12:0] C_GV   = 13'sd833;
    localparam logic signed [12:0] C_GU   = 13'sd400;
    localparam logic signed [12:0] C_BU   = 13'sd2066;
    localparam logic [LUMA_W-1:0]  Y_OFS  = 8'd16;
    localparam logic signed [9:0]  UV_OFS = 10'sd128;
    localparam logic signed [ACC_W-1:0] CH_MAX = 22'sd262143;
    localparam logic [7:0] ALPHA = 8'hff;

    // one item between the index stage and the color stage
    typedef struct packed {
        logic [LUMA_W-1:0]   luma;
        logic [CHROMA_W-1:0] u;
        logic [CHROMA_W-1:0] v;
        logic                fmt;
        logic                emit;
        logic                even;
        logic [INDEX_W-1:0]  index;
        logic                last;
    } t_s1_item;

    function automatic logic [CH_W-1:0] sat_channel(input logic signed [ACC_W-1:0] x);
        logic [CH_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > CH_MAX) begin
            res = CH_MAX[CH_W-1:0];
        end else begin
            res = x[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/y2r_pix_if.sv @@
// y2r pixel channel interfaces: luma/chroma input items and packed output words.
// Depends on y2r_pkg.
`default_nettype none

interface y2r_pix_in_if import y2r_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LUMA_W-1:0]   luma;
    logic [CHROMA_W-1:0] chroma_u;
    logic [CHROMA_W-1:0] chroma_v;

    modport source (output valid, output luma, output chroma_u, output chroma_v,
                    input ready);
    modport sink   (input valid, input luma, input chroma_u, input chroma_v,
                    output ready);
endinterface

interface y2r_pix_out_if import y2r_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  pixel_word;
    logic [INDEX_W-1:0] word_index;
    logic               frame_last;

    modport source (output valid, output pixel_word, output word_index,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_word, input word_index,
                    input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/yuv420sp_to_rgb_converter.sv @@
// yuv420sp_to_rgb_converter: nv12 pixel stream to argb8888 or paired rgb565 words.
// Depends on y2r_pkg and the channel interfaces in y2r_pix_if.sv.
// The block takes one pixel per clock and sustains that rate with a ready
// output; each result passes the stage 0 register, then the output register.
// The first stage tracks row and column, latches chroma on even columns and
// assigns the word index; the second stage does the bt.601 constant multiplies,
// clamps and packing. In rgb565 mode even pixels produce no word, so words come
// out at half the pixel rate. Registers take effect on the next pixel and must
// be written over apb only while the stream is idle; the block does not enforce this.
`default_nettype none

module yuv420sp_to_rgb_converter import y2r_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    y2r_pix_in_if.sink             i_pix,
    y2r_pix_out_if.source          o_pix,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [CFG_ADDR_W-1:0]   paddr,
    input  wire [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // configuration
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic             r_reverse_order;
    logic             r_output_format;
    logic             cfg_wr;
    t_cfg_reg         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = t_cfg_reg'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
            r_reverse_order <= 1'b0;
            r_output_format <= FMT_ARGB8888;
        end else if (cfg_wr) begin
            case (cfg_sel)
                CFG_FRAME_WIDTH:   r_frame_width   <= pwdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT:  r_frame_height  <= pwdata[DIM_W-1:0];
                CFG_REVERSE_ORDER: r_reverse_order <= pwdata[0];
                CFG_OUTPUT_FORMAT: r_output_format <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            CFG_FRAME_WIDTH:   prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, r_frame_width};
            CFG_FRAME_HEIGHT:  prdata = {{(CFG_DATA_W-DIM_W){1'b0}}, r_frame_height};
            CFG_REVERSE_ORDER: prdata = {{(CFG_DATA_W-1){1'b0}}, r_reverse_order};
            CFG_OUTPUT_FORMAT: prdata = {{(CFG_DATA_W-1){1'b0}}, r_output_format};
            default:           prdata = '0;
        endcase
    end

    // effective frame size
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [2*DIM_W-1:0] pixels;
    logic [2*DIM_W-1:0] pix_m1;
    logic [2*DIM_W-2:0] pairs_m1;

    always_comb begin
        w_eff = r_frame_width;
        if (r_frame_width < 13'd2) begin
            w_eff = 13'd2;
        end else if (r_frame_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        w_eff[0] = 1'b0;
        h_eff = r_frame_height;
        if (r_frame_height < 13'd1) begin
            h_eff = 13'd1;
        end else if (r_frame_height > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    assign pixels   = w_eff * h_eff;
    assign pix_m1   = pixels - 1'b1;
    assign pairs_m1 = pixels[2*DIM_W-1:1] - 1'b1;

    // stage 0: position, chroma hold, index
    logic [CNT_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [CHROMA_W-1:0] r_held_u;
    logic [CHROMA_W-1:0] r_held_v;
    logic [INDEX_W-1:0]  r_out_index;

    logic [DIM_W-1:0]   col1, row1, col2, row2, col3, row3;
    logic               frame_start;
    logic               even;
    logic               emit;
    logic               last;
    logic [INDEX_W-1:0] start_idx;
    logic [INDEX_W-1:0] idx_cur;
    logic [CNT_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [INDEX_W-1:0] n_out_index;
    t_s1_item           n_s1;
    logic               in_acc;
    logic               out_en;

    t_s1_item           r_s1;
    logic               r_s1_valid;

    always_comb begin
        // a column or row beyond the current size ends the row or frame
        col1 = {1'b0, r_col};
        row1 = {1'b0, r_row};
        if (col1 >= w_eff) begin
            col1 = '0;
            row1 = row1 + 1'b1;
        end
        col2 = col1;
        row2 = row1;
        if (row1 >= h_eff) begin
            col2 = '0;
            row2 = '0;
        end
        frame_start = (col2 == '0) && (row2 == '0);
        even        = !col2[0];
        emit        = (r_output_format == FMT_ARGB8888) || !even;
        last        = (row2 == h_eff - 1'b1) && (col2 == w_eff - 1'b1);

        if (!r_reverse_order) begin
            start_idx = '0;
        end else if (r_output_format == FMT_ARGB8888) begin
            start_idx = pix_m1[INDEX_W-1:0];
        end else begin
            start_idx = pairs_m1[INDEX_W-1:0];
        end
        idx_cur = frame_start ? start_idx : r_out_index;

        n_out_index = idx_cur;
        if (emit) begin
            n_out_index = r_reverse_order ? idx_cur - 1'b1 : idx_cur + 1'b1;
        end

        col3 = col2 + 1'b1;
        row3 = row2;
        if (col3 >= w_eff) begin
            col3 = '0;
            row3 = row2 + 1'b1;
            if (row3 >= h_eff) begin
                row3 = '0;
            end
        end
        n_col = col3[CNT_W-1:0];
        n_row = row3[ROW_W-1:0];

        n_s1.luma  = i_pix.luma;
        n_s1.u     = even ? i_pix.chroma_u : r_held_u;
        n_s1.v     = even ? i_pix.chroma_v : r_held_v;
        n_s1.fmt   = r_output_format;
        n_s1.emit  = emit;
        n_s1.even  = even;
        n_s1.index = idx_cur;
        n_s1.last  = last;
    end

    assign out_en      = !o_pix.valid || o_pix.ready;
    assign i_pix.ready = out_en || !r_s1_valid;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_held_u    <= '0;
            r_held_v    <= '0;
            r_out_index <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_index <= n_out_index;
                r_held_u    <= n_s1.u;
                r_held_v    <= n_s1.v;
                r_s1_valid  <= 1'b1;
            end else if (out_en) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // stage 1: color math and packing
    logic [LUMA_W-1:0]        y_u8;
    logic signed [9:0]        y_s, u_s, v_s;
    logic signed [ACC_W-1:0]  r_sum, g_sum, b_sum, y_term;
    logic [CH_W-1:0]          r_ch, g_ch, b_ch;
    logic [15:0]              half;
    logic [WORD_W-1:0]        word;
    logic [15:0]              r_pending_half;
    logic                     s1_adv;

    always_comb begin
        y_u8   = (r_s1.luma < Y_OFS) ? '0 : r_s1.luma - Y_OFS;
        y_s    = $signed({2'b00, y_u8});
        u_s    = $signed({2'b00, r_s1.u}) - UV_OFS;
        v_s    = $signed({2'b00, r_s1.v}) - UV_OFS;
        y_term = C_Y * y_s;
        r_sum  = y_term + C_RV * v_s;
        g_sum  = y_term - C_GV * v_s - C_GU * u_s;
        b_sum  = y_term + C_BU * u_s;
        r_ch   = sat_channel(r_sum);
        g_ch   = sat_channel(g_sum);
        b_ch   = sat_channel(b_sum);
        half   = {r_ch[17:13], g_ch[17:12], b_ch[17:13]};
        if (r_s1.fmt == FMT_ARGB8888) begin
            word = {ALPHA, r_ch[17:10], g_ch[17:10], b_ch[17:10]};
        end else begin
            word = {r_pending_half, half};
        end
    end

    assign s1_adv = r_s1_valid && out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_half <= '0;
        end else if (s1_adv && (r_s1.fmt == FMT_RGB565) && r_s1.even) begin
            r_pending_half <= half;
        end
    end

    // output register
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [INDEX_W-1:0] r_out_idx;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_word <= word;
            r_out_idx  <= r_s1.index;
            r_out_last <= r_s1.last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_word = r_out_word;
    assign o_pix.word_index = r_out_idx;
    assign o_pix.frame_last = r_out_last;

    // only even rgb565 pixels may skip a word
    a_no_emit_only_rgb565_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.emit) |-> (r_s1.fmt == FMT_RGB565 && r_s1.even))
        else $error("item without word outside rgb565 even column");

    // the last pixel of a frame is on an odd column and always yields a word
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.last) |-> r_s1.emit)
        else $error("frame end item carries no word");

    // a forward frame starts at index zero
    a_fwd_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_start && !r_reverse_order) |=> (r_s1.index == '0))
        else $error("forward frame did not start at index zero");

endmodule

`default_nettype wire
